>>> hdl/vtp_pkg.sv
// Package for the value-to-pseudocolor block: register codes, config bundle, stage counts.
// No dependencies; imported by every module under hdl.
package vtp_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int IDX_LAT   = 10;
	localparam int SHADE_LAT = 11;

	typedef logic [23:0] rgb_t;

	typedef enum logic [2:0] {
		REG_RANGE_LOW   = 3'd0,
		REG_RANGE_HIGH  = 3'd1,
		REG_PAL_SIZE    = 3'd2,
		REG_KEY_COUNT   = 3'd3,
		REG_KEY_PAIR_01 = 3'd4,
		REG_KEY_PAIR_23 = 3'd5,
		REG_KEY_PAIR_45 = 3'd6
	} reg_idx_t;

	// Settings derived from the registers, consumed by the color stages
	typedef struct packed {
		logic [8:0]                  per;
		logic [4:0][11:0]            bnd;
		logic [2:0]                  ivl;
		logic [7:0]                  last_idx;
		rgb_t [KEY_SLOTS-1:0]        keys;
		rgb_t                        last_key;
	} shade_cfg_t;

endpackage

>>> hdl/vtp_index.sv
// Index pipeline: range compare, scale multiply and an 8-stage restoring divider.
// Depends on vtp_pkg.
module vtp_index #(
	parameter int SB = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          sample,
	input  logic signed [SB-1:0] lo,
	input  logic signed [SB-1:0] hi,
	input  logic [7:0]           m,
	input  logic [SB-1:0]        r,
	output logic [7:0]           n
);
	import vtp_pkg::*;

	localparam int PW = SB + 8;

	logic signed [SB-1:0] v;
	logic signed [SB:0]   dfull;

	logic          le_s1, ge_s1;
	logic [SB-1:0] d_s1;

	logic [PW-1:0] rem_s [0:8];
	logic [7:0]    quo_s [0:8];
	logic          le_s  [0:8];
	logic          ge_s  [0:8];

	assign v     = sample[SB-1:0];
	assign dfull = (SB+1)'(v) - (SB+1)'(lo);

	always_ff @(posedge clk) begin
		if (en) begin
			le_s1 <= (v <= lo);
			ge_s1 <= (v >= hi);
			d_s1  <= dfull[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= PW'(m) * PW'(d_s1);
			quo_s[0] <= '0;
			le_s[0]  <= le_s1;
			ge_s[0]  <= ge_s1;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < 8; k++) begin : g_div
		logic [PW-1:0] dsh;
		logic          take;
		assign dsh  = PW'(r) << (7 - k);
		assign take = (rem_s[k] >= dsh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - dsh : rem_s[k];
				quo_s[k+1] <= quo_s[k] | (take ? 8'(1) << (7 - k) : 8'd0);
				le_s[k+1]  <= le_s[k];
				ge_s[k+1]  <= ge_s[k];
			end
		end
	end

	assign n = le_s[8] ? 8'd0 : (ge_s[8] ? m : quo_s[8]);

endmodule

>>> hdl/vtp_shade.sv
// Color pipeline: interval select, per-channel step multiply, divide by entries per interval.
// Depends on vtp_pkg; the last stage is the output register.
module vtp_shade (
	input  logic               clk,
	input  logic               en,
	input  logic [7:0]         n,
	input  vtp_pkg::shade_cfg_t cfg,
	output logic [7:0]         palette_index,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);
	import vtp_pkg::*;

	logic [2:0]  cnt;
	logic [11:0] base;
	logic        fin;

	logic [7:0] n_s1, j_s1;
	logic [2:0] i_s1;
	logic       fin_s1;

	always_comb begin
		cnt = '0;
		for (int k = 1; k <= 5; k++) begin
			if (3'(k) <= cfg.ivl && 12'(n) >= cfg.bnd[k-1])
				cnt = cnt + 3'd1;
		end
		base = (cnt == 3'd0) ? 12'd0 : cfg.bnd[cnt - 3'd1];
		fin  = (cnt == cfg.ivl) || (n == cfg.last_idx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= n;
			i_s1   <= cnt;
			j_s1   <= n - base[7:0];
			fin_s1 <= fin;
		end
	end

	logic [2:0] ka, kb;
	rgb_t       ca, cb;
	assign ka = (i_s1 <= 3'd4) ? i_s1 : 3'd0;
	assign kb = ka + 3'd1;
	assign ca = cfg.keys[ka];
	assign cb = cfg.keys[kb];

	logic [2:0][7:0]  ca_s [0:8];
	logic [2:0]       neg_s [0:8];
	logic [2:0][16:0] rem_s [0:8];
	logic [2:0][7:0]  quo_s [0:8];
	logic [7:0]       n_s   [0:8];
	logic             fin_s [0:8];

	// hold the magnitude of each channel step times position
	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [8:0] diff;
		logic [8:0] mag;
		assign diff = {1'b0, cb[8*c +: 8]} - {1'b0, ca[8*c +: 8]};
		assign mag  = diff[8] ? 9'd0 - diff : diff;
		always_ff @(posedge clk) begin
			if (en) begin
				ca_s[0][c]  <= ca[8*c +: 8];
				neg_s[0][c] <= diff[8];
				rem_s[0][c] <= 17'(mag[7:0]) * 17'(j_s1);
				quo_s[0][c] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]   <= n_s1;
			fin_s[0] <= fin_s1;
		end
	end

	for (genvar k = 0; k < 8; k++) begin : g_div
		logic [16:0] dsh;
		assign dsh = 17'(cfg.per) << (7 - k);
		for (genvar c = 0; c < 3; c++) begin : g_dch
			logic take;
			assign take = (rem_s[k][c] >= dsh);
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][c] <= take ? rem_s[k][c] - dsh : rem_s[k][c];
					quo_s[k+1][c] <= quo_s[k][c] | (take ? 8'(1) << (7 - k) : 8'd0);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ca_s[k+1]  <= ca_s[k];
				neg_s[k+1] <= neg_s[k];
				n_s[k+1]   <= n_s[k];
				fin_s[k+1] <= fin_s[k];
			end
		end
	end

	rgb_t col;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			col[8*c +: 8] = neg_s[8][c] ? ca_s[8][c] - quo_s[8][c]
			                            : ca_s[8][c] + quo_s[8][c];
		end
		if (fin_s[8])
			col = cfg.last_key;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			palette_index <= n_s[8];
			red           <= col[23:16];
			green         <= col[15:8];
			blue          <= col[7:0];
		end
	end

endmodule

>>> hdl/value_to_pseudocolor_top.sv
// 21 register stages; one sample per cycle while no finished result is stalled on out_ready.
// The 8-stage index divider and the 8-stage channel divider set the depth.
// The whole pipeline stalls only while a finished result waits on out_ready.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
// Depends on vtp_pkg, vtp_index and vtp_shade.
module value_to_pseudocolor_top #(
	parameter int MAX_KEYS    = 6,
	parameter int MAX_COLORS  = 256,
	parameter int SAMPLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  palette_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import vtp_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int LAT = IDX_LAT + SHADE_LAT;

	logic [31:0] range_low_q, range_high_q;
	logic [8:0]  pal_size_q;
	logic [2:0]  key_count_q;
	logic [47:0] pair01_q, pair23_q, pair45_q;

	reg_idx_t ridx;
	logic     wr;
	assign ridx   = reg_idx_t'(paddr[5:3]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
			pal_size_q   <= 9'd256;
			key_count_q  <= 3'd2;
			pair01_q     <= '0;
			pair23_q     <= '0;
			pair45_q     <= '0;
		end else if (wr) begin
			unique case (ridx)
				REG_RANGE_LOW:   range_low_q  <= pwdata[31:0];
				REG_RANGE_HIGH:  range_high_q <= pwdata[31:0];
				REG_PAL_SIZE:    pal_size_q   <= pwdata[8:0];
				REG_KEY_COUNT:   key_count_q  <= pwdata[2:0];
				REG_KEY_PAIR_01: pair01_q     <= pwdata[47:0];
				REG_KEY_PAIR_23: pair23_q     <= pwdata[47:0];
				REG_KEY_PAIR_45: pair45_q     <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_RANGE_LOW:   prdata = 64'(range_low_q);
			REG_RANGE_HIGH:  prdata = 64'(range_high_q);
			REG_PAL_SIZE:    prdata = 64'(pal_size_q);
			REG_KEY_COUNT:   prdata = 64'(key_count_q);
			REG_KEY_PAIR_01: prdata = 64'(pair01_q);
			REG_KEY_PAIR_23: prdata = 64'(pair23_q);
			REG_KEY_PAIR_45: prdata = 64'(pair45_q);
			default:         prdata = '0;
		endcase
	end

	// derived settings, refreshed every cycle from the registers
	logic [8:0]  size_c;
	logic [2:0]  keys_c, ivl_c;
	logic [8:0]  per_c;
	logic [16:0] mul3, mul5;
	rgb_t [KEY_SLOTS-1:0] keys_w;
	logic signed [SB-1:0] lo_c, hi_c;
	logic [SB:0] r_full;

	always_comb begin
		if (pal_size_q < 9'd2)
			size_c = 9'd2;
		else if (pal_size_q > 9'(MAX_COLORS))
			size_c = 9'(MAX_COLORS);
		else
			size_c = pal_size_q;
		if (key_count_q < 3'd2)
			keys_c = 3'd2;
		else if (key_count_q > 3'(MAX_KEYS))
			keys_c = 3'(MAX_KEYS);
		else
			keys_c = key_count_q;
		ivl_c = keys_c - 3'd1;
		mul3  = 17'(size_c) * 17'd171;
		mul5  = 17'(size_c) * 17'd205;
		// entries per interval by reciprocal, exact for sizes up to 256
		case (ivl_c)
			3'd1:    per_c = size_c;
			3'd2:    per_c = size_c >> 1;
			3'd3:    per_c = 9'(mul3 >> 9);
			3'd4:    per_c = size_c >> 2;
			3'd5:    per_c = 9'(mul5 >> 10);
			default: per_c = size_c;
		endcase
		keys_w = {pair45_q[47:24], pair45_q[23:0], pair23_q[47:24], pair23_q[23:0],
		          pair01_q[47:24], pair01_q[23:0]};
		lo_c   = range_low_q[SB-1:0];
		hi_c   = range_high_q[SB-1:0];
		r_full = (SB+1)'(hi_c) - (SB+1)'(lo_c);
	end

	shade_cfg_t           cfg_q;
	logic [8:0]           size_q;
	logic [SB-1:0]        r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			size_q <= '0;
			r_q    <= '0;
		end else begin
			cfg_q.per      <= per_c;
			for (int k = 0; k < 5; k++)
				cfg_q.bnd[k] <= 12'(per_c) * 12'(k + 1);
			cfg_q.ivl      <= ivl_c;
			cfg_q.last_idx <= 8'(size_c - 9'd1);
			cfg_q.keys     <= keys_w;
			cfg_q.last_key <= keys_w[ivl_c];
			size_q         <= size_c;
			r_q            <= r_full[SB-1:0];
		end
	end

	// advance everything unless a finished result is held
	logic           adv;
	logic [LAT-1:0] vld_q;
	assign adv       = ~vld_q[LAT-1] | out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	logic [7:0] n_w;

	// the compare stage reads the range registers directly
	vtp_index #(.SB(SB)) u_index (
		.clk    (clk),
		.en     (adv),
		.sample (sample),
		.lo     (lo_c),
		.hi     (hi_c),
		.m      (cfg_q.last_idx),
		.r      (r_q),
		.n      (n_w)
	);

	vtp_shade u_shade (
		.clk           (clk),
		.en            (adv),
		.n             (n_w),
		.cfg           (cfg_q),
		.palette_index (palette_index),
		.red           (red),
		.green         (green),
		.blue          (blue)
	);

`ifndef SYNTHESIS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted request did not enter the pipeline");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved during a stall");
	a_per: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.per <= size_q)
		else $error("entries per interval exceed palette size");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for value_to_pseudocolor_top: APB register setup, directed
// and random samples, colour prediction per sample. Depends on vtp_pkg and the top level.
module tb;
	import vtp_pkg::*;

	localparam int LAT = 21;

	typedef struct {
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	typedef struct {
		logic [31:0] v;
		logic        fixed;
		logic [7:0]  idx;
		logic [23:0] rgb;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [31:0] sample;
	logic        out_valid, out_ready;
	logic [7:0]  palette_index, red, green, blue;

	// shadow registers
	logic [31:0] lo_r, hi_r;
	logic [8:0]  size_r;
	logic [2:0]  keys_r;
	logic [47:0] kp01, kp23, kp45;

	color_t pending[$];
	int     fails;
	int     idle_pct_in, idle_pct_out;
	bit     hold_off;

	value_to_pseudocolor_top u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .palette_index(palette_index),
		.red(red), .green(green), .blue(blue)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [23:0] key_rgb(int k);
		logic [47:0] p;
		p = (k < 2) ? kp01 : (k < 4) ? kp23 : kp45;
		return (k % 2) ? p[47:24] : p[23:0];
	endfunction

	function automatic color_t shade_of(logic [31:0] s);
		color_t c;
		int size, keys, ivl, per, n, i, j, ca, diff;
		longint v, lo, hi;
		logic [23:0] col, a, b;
		size = size_r; keys = keys_r;
		if (size < 2) size = 2;
		if (size > 256) size = 256;
		if (keys < 2) keys = 2;
		if (keys > 6) keys = 6;
		v = longint'($signed(s)); lo = longint'($signed(lo_r)); hi = longint'($signed(hi_r));
		if (v <= lo) n = 0;
		else if (v >= hi) n = size - 1;
		else n = int'((longint'(size - 1) * (v - lo)) / (hi - lo));
		ivl = keys - 1;
		per = size / ivl;
		col = key_rgb(keys - 1);
		if (n != size - 1 && per != 0 && n / per < ivl) begin
			i = n / per; j = n % per;
			a = key_rgb(i); b = key_rgb(i + 1);
			for (int s8 = 0; s8 < 24; s8 += 8) begin
				ca = (a >> s8) & 8'hff;
				diff = int'((b >> s8) & 8'hff) - ca;
				col[s8 +: 8] = 8'(ca + (diff * j) / per);
			end
		end
		c.idx = n[7:0]; c.r = col[23:16]; c.g = col[15:8]; c.b = col[7:0];
		return c;
	endfunction

	task automatic write_reg(reg_idx_t ri, logic [63:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(8 * ri); pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (ri)
			REG_RANGE_LOW:   lo_r = val[31:0];
			REG_RANGE_HIGH:  hi_r = val[31:0];
			REG_PAL_SIZE:    size_r = val[8:0];
			REG_KEY_COUNT:   keys_r = val[2:0];
			REG_KEY_PAIR_01: kp01 = val[47:0];
			REG_KEY_PAIR_23: kp23 = val[47:0];
			REG_KEY_PAIR_45: kp45 = val[47:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic setup(int lo, int hi, int sz, int kc, logic [47:0] a,
			logic [47:0] b, logic [47:0] c);
		write_reg(REG_RANGE_LOW, 64'(lo));
		write_reg(REG_RANGE_HIGH, 64'(hi));
		write_reg(REG_PAL_SIZE, 64'(sz));
		write_reg(REG_KEY_COUNT, 64'(kc));
		write_reg(REG_KEY_PAIR_01, 64'(a));
		write_reg(REG_KEY_PAIR_23, 64'(b));
		write_reg(REG_KEY_PAIR_45, 64'(c));
	endtask

	// offer one request, then hold it until accepted
	task automatic send_sample(logic [31:0] s, logic fixed, color_t want);
		color_t c;
		while ($urandom_range(99) < idle_pct_in) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; sample <= s;
		do @(posedge clk); while (!in_ready);
		c = fixed ? want : shade_of(s);
		pending.push_back(c);
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (pending.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (LAT + 5) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_sample();
		int m;
		m = $urandom_range(9);
		if (m == 0) return $urandom;
		if (m == 1) return lo_r + $urandom_range(2) - 1;
		if (m == 2) return hi_r + $urandom_range(2) - 1;
		if ($signed(hi_r) > $signed(lo_r))
			return lo_r + 32'(longint'($urandom) % (longint'($signed(hi_r)) -
				longint'($signed(lo_r)) + 1));
		return $urandom;
	endfunction

	// output side: random stall, plus one long hold-off
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= !hold_off && ($urandom_range(99) >= idle_pct_out);
		end
	end

	always @(posedge clk) begin
		color_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("result with nothing expected: idx %0d", palette_index);
				fails++;
			end else begin
				w = pending.pop_front();
				if (palette_index !== w.idx) begin
					$error("palette_index exp %0d got %0d", w.idx, palette_index); fails++;
				end
				if (red !== w.r) begin
					$error("red exp %0d got %0d", w.r, red); fails++;
				end
				if (green !== w.g) begin
					$error("green exp %0d got %0d", w.g, green); fails++;
				end
				if (blue !== w.b) begin
					$error("blue exp %0d got %0d", w.b, blue); fails++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		color_t want;
		logic [47:0] ka, kb, kc;
		fails = 0; hold_off = 0;
		idle_pct_in = 34; idle_pct_out = 34;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; sample = 0;
		lo_r = 0; hi_r = 0; size_r = 256; keys_r = 2; kp01 = 0; kp23 = 0; kp45 = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// after reset: empty range, black keys
		rows = '{
			'{32'h0, 1, 8'd0, 24'h0},
			'{32'h1, 1, 8'd255, 24'h0},
			'{32'h8000_0000, 1, 8'd0, 24'h0},
			'{32'h7fff_ffff, 1, 8'd255, 24'h0}
		};
		foreach (rows[k]) begin
			want.idx = rows[k].idx;
			{want.r, want.g, want.b} = rows[k].rgb;
			send_sample(rows[k].v, rows[k].fixed, want);
		end
		drain();

		// full range, extremes and interpolation over six keys
		setup(32'h8000_0000, 32'h7fff_ffff, 256, 6,
			48'hffffff_000000, 48'h00ff00_ff0000, 48'h808080_0000ff);
		rows = '{
			'{32'h8000_0000, 1, 8'd0, 24'h000000},
			'{32'h7fff_ffff, 1, 8'd255, 24'h808080},
			'{32'h8000_0001, 0, 0, 0},
			'{32'h7fff_fffe, 0, 0, 0},
			'{32'h0, 0, 0, 0},
			'{32'hffff_ffff, 0, 0, 0},
			'{32'h5555_5555, 0, 0, 0},
			'{32'haaaa_aaaa, 0, 0, 0}
		};
		foreach (rows[k]) begin
			want.idx = rows[k].idx;
			{want.r, want.g, want.b} = rows[k].rgb;
			send_sample(rows[k].v, rows[k].fixed, want);
		end
		drain();

		// inverted range; size and key count out of range
		setup(100, -100, 0, 7, 48'h123456_abcdef, 48'h0, 48'h0);
		for (int k = 0; k < 4; k++) send_sample(32'(k * 150 - 200), 0, want);
		drain();
		// fewer entries than intervals, and size above maximum
		setup(0, 10, 3, 6, 48'hff00ff_00ff00, 48'h0, 48'h0f0f0f_f0f0f0);
		for (int k = -1; k < 12; k += 3) send_sample(32'(k), 0, want);
		drain();
		setup(-5, 5, 511, 1, 48'hffffff_000000, 48'h0, 48'h0);
		for (int k = -6; k < 7; k += 4) send_sample(32'(k), 0, want);
		drain();

		// random phases; one long stretch with no idling
		for (int ph = 0; ph < 10; ph++) begin
			int a, b;
			a = $urandom; b = $urandom;
			if (ph % 3 == 0) begin a = $urandom_range(200) - 100; b = a + $urandom_range(600); end
			if ($signed(a) > $signed(b) && ph % 4 != 1) begin int t; t = a; a = b; b = t; end
			ka = {$urandom, $urandom}; kb = {$urandom, $urandom}; kc = {$urandom, $urandom};
			setup(a, b, (ph == 1) ? 2 : (ph == 2) ? 256 : $urandom_range(511),
				(ph == 3) ? 0 : $urandom_range(7), ka, kb, kc);
			idle_pct_in = (ph == 5) ? 0 : 34;
			idle_pct_out = (ph == 5) ? 0 : 34;
			if (ph == 6) begin
				fork
					begin
						hold_off = 1;
						repeat (200) @(negedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int k = 0; k < 50; k++) send_sample(rand_sample(), 0, want);
			drain();
		end

		if (fails == 0 && pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

>>> value_to_pseudocolor_top.f
hdl/vtp_pkg.sv
hdl/vtp_index.sv
hdl/vtp_shade.sv
hdl/value_to_pseudocolor_top.sv
verif/tb.sv
